// ===== rtl/clt_pkg.sv =====
// Shared types and constants for the character LCD text cursor block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package clt_pkg;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 8;
   localparam int WIDTH_W = 6;
   localparam int CNT_W   = 6;

   // Default line stride of the display address map
   localparam int LINE_STRIDE_DEFAULT = 40;

   // Display codes and addresses
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
   localparam logic [CHAR_W-1:0]  SET_ADDR_CMD     = 8'h80;
   localparam logic [ADDR_W-1:0]  SECOND_LINE_ADDR = 8'd40;
   localparam logic [CNT_W-1:0]   MAX_BLANKS       = 6'd40;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET      = 6'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic emit_char;   // accept a printable char, write it, advance address
      logic start_nl;    // accept a newline, clear the blank count
      logic emit_blank;  // write one space, advance address
      logic emit_cmd;    // move to the other line, write set-address command
   } clt_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_newline;  // offered char is a newline
      logic blank_more;  // another space is due on this newline
   } clt_status_type;

endpackage

`default_nettype wire

// ===== rtl/clt_req_if.sv =====
// Input channel: one character byte per transaction, valid/ready handshake.
// Depends on clt_pkg for the field width.
`default_nettype none

interface clt_req_if;
   logic                       valid;
   logic                       ready;
   logic [clt_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/clt_rsp_if.sv =====
// Result channel: one display bus write per transaction, valid/ready handshake.
// Depends on clt_pkg for the field width.
`default_nettype none

interface clt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       is_data;
   logic [clt_pkg::CHAR_W-1:0] bus_byte;
   logic                       last;

   modport source (output valid, output is_data, output bus_byte, output last, input ready);
   modport sink   (input valid, input is_data, input bus_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/clt_ctrl.sv =====
// Controller for the text cursor: sequences newline blanking and owns the
// handshakes of both channels. Depends on clt_pkg for command/status types.
`default_nettype none

module clt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  clt_pkg::clt_status_type status,
   output clt_pkg::clt_cmd_type    cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BLANK = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic accept;
   logic emit_any;

   // Output slot can take a new transaction when empty or draining now
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Decode commands
   always_comb begin
      cmd            = '0;
      cmd.emit_char  = accept && !status.is_newline;
      cmd.start_nl   = accept && status.is_newline;
      cmd.emit_blank = (state_ff == ST_BLANK) && out_free && status.blank_more;
      cmd.emit_cmd   = (state_ff == ST_BLANK) && out_free && !status.blank_more;
   end

   assign emit_any = cmd.emit_char || cmd.emit_blank || cmd.emit_cmd;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_nl) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (cmd.emit_cmd) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Fill on emit, drain on ready
   always_comb begin
      if (emit_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/clt_datapath.sv =====
// Datapath for the text cursor: address and column tracking, blank count,
// width register and the result payload register. Depends on clt_pkg.
`default_nettype none

module clt_datapath #(
   parameter int LINE_STRIDE = clt_pkg::LINE_STRIDE_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_we,
   input  wire  [clt_pkg::WIDTH_W-1:0]   csr_wdata,
   input  wire  [clt_pkg::CHAR_W-1:0]    char_code,
   input  clt_pkg::clt_cmd_type          cmd,
   output clt_pkg::clt_status_type       status,
   output logic                          rsp_is_data,
   output logic [clt_pkg::CHAR_W-1:0]    rsp_bus_byte,
   output logic                          rsp_last
);

   localparam int ColW = $clog2(LINE_STRIDE);
   localparam int CmpW = 7;
   localparam logic [ColW-1:0] ColLast = ColW'(LINE_STRIDE - 1);
   localparam logic [ColW-1:0] SecondLineCol =
      ColW'(int'(clt_pkg::SECOND_LINE_ADDR) % LINE_STRIDE);
   localparam logic [clt_pkg::ADDR_W-1:0] StrideAddr = clt_pkg::ADDR_W'(LINE_STRIDE);

   logic [clt_pkg::ADDR_W-1:0]  addr_ff,  addr_in;
   logic [ColW-1:0]             col_ff,   col_in;
   logic [clt_pkg::CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [clt_pkg::WIDTH_W-1:0] width_ff, width_in;
   logic                        is_data_ff, is_data_in;
   logic [clt_pkg::CHAR_W-1:0]  byte_ff,  byte_in;
   logic                        last_ff,  last_in;

   logic [clt_pkg::ADDR_W-1:0]  addr_inc;
   logic [ColW-1:0]             col_inc;
   logic                        on_first_line;
   logic [clt_pkg::ADDR_W-1:0]  line_addr;
   logic [ColW-1:0]             line_col;

   // Column mirrors address mod stride; an address wrap restarts it at zero
   assign addr_inc = addr_ff + 1'b1;
   always_comb begin
      if (addr_ff == '1 || col_ff == ColLast) begin
         col_inc = '0;
      end else begin
         col_inc = col_ff + 1'b1;
      end
   end

   // Line switch target
   assign on_first_line = addr_ff < StrideAddr;
   assign line_addr = on_first_line ? clt_pkg::SECOND_LINE_ADDR : '0;
   assign line_col  = on_first_line ? SecondLineCol : '0;

   // Status to the controller
   assign status.is_newline = char_code == clt_pkg::NEWLINE_CODE;
   assign status.blank_more = (cnt_ff != clt_pkg::MAX_BLANKS) &&
                              (CmpW'(col_ff) < CmpW'(width_ff));

   // Cursor, blank count and width update
   always_comb begin
      addr_in  = addr_ff;
      col_in   = col_ff;
      cnt_in   = cnt_ff;
      width_in = csr_we ? csr_wdata : width_ff;
      if (cmd.emit_char || cmd.emit_blank) begin
         addr_in = addr_inc;
         col_in  = col_inc;
      end else if (cmd.emit_cmd) begin
         addr_in = line_addr;
         col_in  = line_col;
      end
      if (cmd.start_nl) begin
         cnt_in = '0;
      end else if (cmd.emit_blank) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Load the result payload
   always_comb begin
      is_data_in = is_data_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      if (cmd.emit_char) begin
         is_data_in = 1'b1;
         byte_in    = char_code;
         last_in    = 1'b1;
      end else if (cmd.emit_blank) begin
         is_data_in = 1'b1;
         byte_in    = clt_pkg::SPACE_CODE;
         last_in    = 1'b0;
      end else if (cmd.emit_cmd) begin
         is_data_in = 1'b0;
         byte_in    = clt_pkg::SET_ADDR_CMD | {1'b0, line_addr[clt_pkg::ADDR_W-2:0]};
         last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         col_ff   <= '0;
         width_ff <= clt_pkg::WIDTH_RESET;
      end else begin
         addr_ff  <= addr_in;
         col_ff   <= col_in;
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      is_data_ff <= is_data_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   assign rsp_is_data  = is_data_ff;
   assign rsp_bus_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

// ===== rtl/char_lcd_text_cursor_core.sv =====
// Character LCD text cursor: controller and datapath, top level.
// Depends on clt_pkg, clt_req_if, clt_rsp_if, clt_ctrl and clt_datapath.
//
// Usage:
//   req_ch carries one character byte per transaction; rsp_ch carries one
//   display bus write per transaction (is_data, bus_byte, last). csr_we with
//   csr_wdata writes visible_width; write it only while the block is idle.
//   A printable character gives one data write in the cycle after acceptance and
//   a new character may follow in the very next cycle while rsp_ch.ready is high.
//   A newline gives spaces until the column reaches visible_width (at most 40)
//   and then one set-address command, one result per cycle while rsp_ch.ready
//   is high; the blanking sequencer emits these writes.
//   req_ch.ready is low while a newline is being expanded.
//   A single output register holds the pending result; while rsp_ch.ready is
//   low it holds, no result is lost, and the block stops advancing.
//   Reset (synchronous, active high) clears the cursor address to 0, sets
//   visible_width to 16 and empties the output register.
`default_nettype none

module char_lcd_text_cursor_core #(
   parameter int LINE_STRIDE = clt_pkg::LINE_STRIDE_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   clt_req_if.sink                     req_ch,
   clt_rsp_if.source                   rsp_ch,
   input  wire                         csr_we,
   input  wire  [clt_pkg::WIDTH_W-1:0] csr_wdata
);

   clt_pkg::clt_cmd_type    cmd;
   clt_pkg::clt_status_type status;

   // Sequencer and handshakes
   clt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Cursor tracking and result payload
   clt_datapath #(
      .LINE_STRIDE (LINE_STRIDE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .char_code    (req_ch.char_code),
      .cmd          (cmd),
      .status       (status),
      .rsp_is_data  (rsp_ch.is_data),
      .rsp_bus_byte (rsp_ch.bus_byte),
      .rsp_last     (rsp_ch.last)
   );

`ifndef ASSERT_OFF
   // At most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // Every emitted write shows up on the result channel next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_char || cmd.emit_blank || cmd.emit_cmd) |=> rsp_ch.valid)
      else $error("emitted write not presented");

   // A command write always closes its transaction group
   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.is_data) |-> (rsp_ch.last && rsp_ch.bus_byte[7]))
      else $error("command write without last or set-address bit");

   // No new character is taken while blanking is underway
   a_no_accept_blank: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_blank |-> !req_ch.ready)
      else $error("input accepted during newline expansion");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_char_lcd_text_cursor_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_text_cursor_core: drives characters and width
// writes, predicts every display bus write and compares it with the result channel.
// Depends on clt_pkg, clt_req_if, clt_rsp_if and the RTL under rtl/.

module tb_char_lcd_text_cursor_core;

   localparam int STRIDE      = clt_pkg::LINE_STRIDE_DEFAULT;
   localparam int RANDOM_GOAL = 340;

   // One display bus write as seen on the result channel
   typedef struct packed {
      logic                       is_data;
      logic [clt_pkg::CHAR_W-1:0] bus_byte;
      logic                       last;
   } bus_write_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_we;
   logic [clt_pkg::WIDTH_W-1:0] csr_wdata;

   clt_req_if char_bus ();
   clt_rsp_if write_bus ();

   // Cursor and width as the block should hold them
   logic [clt_pkg::ADDR_W-1:0]  cursor_model;
   logic [clt_pkg::WIDTH_W-1:0] width_model;

   logic [clt_pkg::CHAR_W-1:0] pending_chars[$];
   bus_write_type              expected_writes[$];

   int  error_count;
   int  char_gap;
   int  rsp_stall;
   bit  quiet_phase;
   int  random_items;

   char_lcd_text_cursor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (char_bus),
      .rsp_ch    (write_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Mostly no pause, some short, a few long; none at all in a quiet phase
   function automatic int draw_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60)
         draw_pause = 0;
      else if (roll < 90)
         draw_pause = $urandom_range(1, 3);
      else
         draw_pause = $urandom_range(4, 20);
   endfunction

   // Any byte but newline
   function automatic logic [clt_pkg::CHAR_W-1:0] draw_glyph();
      int v;
      v = $urandom_range(0, 254);
      if (v >= int'(clt_pkg::NEWLINE_CODE))
         v++;
      draw_glyph = v[clt_pkg::CHAR_W-1:0];
   endfunction

   function automatic bus_write_type make_write(input logic is_data,
                                                input logic [clt_pkg::CHAR_W-1:0] bus_byte,
                                                input logic last);
      bus_write_type w;
      w.is_data  = is_data;
      w.bus_byte = bus_byte;
      w.last     = last;
      make_write = w;
   endfunction

   // Work out the bus writes that one accepted character causes
   task automatic predict_char(input logic [clt_pkg::CHAR_W-1:0] code);
      int blanks;
      blanks = 0;
      if (code != clt_pkg::NEWLINE_CODE) begin
         expected_writes.push_back(make_write(1'b1, code, 1'b1));
         cursor_model++;
      end else begin
         // blank the rest of the visible line, capped, address wrapping at 256
         while (blanks < int'(clt_pkg::MAX_BLANKS) &&
                (int'(cursor_model) % STRIDE) < int'(width_model)) begin
            expected_writes.push_back(make_write(1'b1, clt_pkg::SPACE_CODE, 1'b0));
            blanks++;
            cursor_model++;
         end
         // jump to the other line
         if (int'(cursor_model) / STRIDE == 0)
            cursor_model = clt_pkg::SECOND_LINE_ADDR;
         else
            cursor_model = '0;
         expected_writes.push_back(make_write(1'b0,
            clt_pkg::SET_ADDR_CMD | {1'b0, cursor_model[6:0]}, 1'b1));
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_write();
      bus_write_type want;
      if (expected_writes.size() == 0) begin
         report_mismatch($sformatf("unexpected write is_data=%b byte=%h last=%b",
            write_bus.is_data, write_bus.bus_byte, write_bus.last));
      end else begin
         want = expected_writes.pop_front();
         if (write_bus.is_data !== want.is_data)
            report_mismatch($sformatf("is_data %b, want %b", write_bus.is_data, want.is_data));
         if (write_bus.bus_byte !== want.bus_byte)
            report_mismatch($sformatf("bus_byte %h, want %h", write_bus.bus_byte,
               want.bus_byte));
         if (write_bus.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", write_bus.last, want.last));
      end
   endtask

   // Driver: offer queued characters, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         char_bus.valid     <= 1'b0;
         char_bus.char_code <= '0;
         char_gap = 0;
      end else begin
         if (char_bus.valid && char_bus.ready)
            predict_char(char_bus.char_code);
         if (!char_bus.valid || char_bus.ready) begin
            if (char_gap > 0) begin
               char_gap--;
               char_bus.valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               char_bus.valid     <= 1'b1;
               char_bus.char_code <= pending_chars.pop_front();
               char_gap = draw_pause();
            end else begin
               char_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted write, stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         write_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (write_bus.valid && write_bus.ready)
            check_write();
         if (rsp_stall > 0) begin
            rsp_stall--;
            write_bus.ready <= 1'b0;
         end else begin
            write_bus.ready <= 1'b1;
            rsp_stall = draw_pause();
         end
      end
   end

   task automatic write_width(input logic [clt_pkg::WIDTH_W-1:0] w);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      width_model = w;
   endtask

   // Wait until every character is taken and every write has come back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_chars.size() != 0 || char_bus.valid || expected_writes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_chars(input logic [clt_pkg::CHAR_W-1:0] codes[$]);
      @(negedge clock);
      foreach (codes[i])
         pending_chars.push_back(codes[i]);
      random_items += codes.size();
   endtask

   // Printable run that ends with the cursor on a chosen address, then a newline
   task automatic queue_long_run(input int target);
      int run_len;
      run_len = (target - int'(cursor_model)) & 8'hFF;
      @(negedge clock);
      repeat (run_len) pending_chars.push_back(draw_glyph());
      pending_chars.push_back(clt_pkg::NEWLINE_CODE);
      random_items += run_len + 1;
   endtask

   initial begin
      logic [clt_pkg::CHAR_W-1:0] batch[$];
      int lines;
      int run_len;
      int phase_idx;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      error_count        = 0;
      quiet_phase        = 1'b0;
      random_items       = 0;
      cursor_model       = '0;
      width_model        = clt_pkg::WIDTH_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset width: extreme bytes, newline from each line
      batch = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h41, clt_pkg::NEWLINE_CODE,
                clt_pkg::NEWLINE_CODE, clt_pkg::NEWLINE_CODE};
      queue_chars(batch);
      wait_drained();

      // Width one: column already past the visible width
      write_width(6'd1);
      batch = '{8'h42, clt_pkg::NEWLINE_CODE, 8'h43, clt_pkg::NEWLINE_CODE};
      queue_chars(batch);
      wait_drained();

      // Zero width: newline gives only the set-address command
      write_width(6'd0);
      batch = '{clt_pkg::NEWLINE_CODE, clt_pkg::NEWLINE_CODE, 8'h44, clt_pkg::NEWLINE_CODE};
      queue_chars(batch);
      wait_drained();

      // Blank cap at full and beyond-stride width
      write_width(6'd40);
      batch = '{clt_pkg::NEWLINE_CODE, clt_pkg::NEWLINE_CODE};
      queue_chars(batch);
      wait_drained();
      write_width(6'd63);
      batch = '{clt_pkg::NEWLINE_CODE, 8'h7F, clt_pkg::NEWLINE_CODE};
      queue_chars(batch);
      wait_drained();

      // Address wrap while blanking, from near the top of the address range;
      // the column restarts at zero after the wrap and blanking goes on
      write_width(6'd16);
      queue_long_run(250);
      wait_drained();

      // Random phases: mostly text lines ended by a newline, some noise
      phase_idx = 0;
      while (random_items < RANDOM_GOAL) begin
         case ($urandom_range(0, 5))
            0:       write_width(6'd0);
            1:       write_width(6'd63);
            2:       write_width(6'($urandom_range(1, 40)));
            default: write_width(6'($urandom_range(0, 63)));
         endcase
         quiet_phase = ($urandom_range(0, 3) == 0);
         // now and then park the cursor high, beyond the second line
         if (phase_idx % 3 == 2)
            queue_long_run($urandom_range(120, 255));
         batch.delete();
         lines = $urandom_range(3, 6);
         repeat (lines) begin
            case ($urandom_range(0, 9))
               0: batch.push_back(draw_glyph());
               1: begin
                  batch.push_back(clt_pkg::NEWLINE_CODE);
                  batch.push_back(clt_pkg::NEWLINE_CODE);
               end
               2, 3: begin
                  run_len = $urandom_range(0, 3);
                  repeat (run_len) batch.push_back(draw_glyph());
                  batch.push_back(clt_pkg::NEWLINE_CODE);
               end
               default: begin
                  run_len = $urandom_range(0, int'(width_model) + 3);
                  repeat (run_len) batch.push_back(draw_glyph());
                  batch.push_back(clt_pkg::NEWLINE_CODE);
               end
            endcase
         end
         queue_chars(batch);
         wait_drained();
         phase_idx++;
      end

      quiet_phase = 1'b0;
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
